// ===== sv/cau_pkg.sv =====
// Package for the complex arithmetic unit: command and status codes.
// Used by complex_arith_unit; it depends on nothing else.
package cau_pkg;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_SCALE = 3'd4,
    CMD_DIVR  = 3'd5,
    CMD_RECIP = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_SAT    = 2'd1,
    ST_DIVZRO = 2'd2
  } status_e;

endpackage

// ===== sv/complex_arith_unit.sv =====
// Complex arithmetic unit on signed fixed point, fully pipelined with a
// bit-per-stage divider. Depends on cau_pkg for command and status codes.
//
// Channel   Direction  Contents
// s_axis    in         tdata: a_re, a_im, b_re, b_im; tuser: command
// m_axis    out        tdata: res_re, res_im; tuser: status
//
// One transaction enters per cycle while s_axis_tready is high; each one passes
// WORD_BITS + 7 register stages, the output register being the last of them;
// the divider retires one quotient bit per stage.
// Reset clears only valid bits; there is no clearing pass.
// A stalled output is held in the output register; one more result lands in a
// skid register, and only then does the pipeline freeze and s_axis_tready drop.
module complex_arith_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // a_re, a_im, b_re, b_im (lowest first), zero padded to bytes
  input  logic [((4*WORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
  // command
  input  logic [cau_pkg::CMD_BITS-1:0]             s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // res_re, res_im (lowest first), zero padded to bytes
  output logic [((2*WORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // status
  output logic [cau_pkg::STATUS_BITS-1:0]          m_axis_tuser
);

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned SW  = 2 * W + 1;
  localparam int unsigned DB  = 2 * W;
  localparam int unsigned NB  = 2 * W + F;
  localparam int unsigned ODW = ((2 * W + 7) / 8) * 8;

  localparam logic signed [SW-1:0] RND   = SW'(1) << (F - 1);
  localparam logic [W-1:0]         SMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         SMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]           HALFW = (W+1)'(1) << (W - 1);

  typedef struct packed {
    logic                 isdiv;
    logic                 dz;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 neg_re;
    logic                 neg_im;
    logic [DB-1:0]        den;
    logic [DB-1:0]        rem_re;
    logic [DB-1:0]        rem_im;
    logic [W-1:0]         nq_re;
    logic [W-1:0]         nq_im;
    logic signed [SW-1:0] val_re;
    logic signed [SW-1:0] val_im;
  } dstage_t;

  logic en;
  logic skid_valid_q;

  assign en            = ~skid_valid_q;
  assign s_axis_tready = en;

  // ---------------- stage 1: input register ----------------
  logic                  s1_valid_q;
  cau_pkg::cmd_e         s1_cmd_q;
  logic signed [W-1:0]   s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q <= cau_pkg::cmd_e'(s_axis_tuser);
      s1_ar_q  <= s_axis_tdata[W-1:0];
      s1_ai_q  <= s_axis_tdata[2*W-1:W];
      s1_br_q  <= s_axis_tdata[3*W-1:2*W];
      s1_bi_q  <= s_axis_tdata[4*W-1:3*W];
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [W-1:0]  sq_x, sq_y;
  logic signed [PW-1:0] p_arbr_d, p_aibi_d, p_arbi_d, p_aibr_d, sq_x_d, sq_y_d;

  // square the divisor: a for real-over-complex, b otherwise
  assign sq_x     = (s1_cmd_q == cau_pkg::CMD_RECIP) ? s1_ar_q : s1_br_q;
  assign sq_y     = (s1_cmd_q == cau_pkg::CMD_RECIP) ? s1_ai_q : s1_bi_q;
  assign p_arbr_d = s1_ar_q * s1_br_q;
  assign p_aibi_d = s1_ai_q * s1_bi_q;
  assign p_arbi_d = s1_ar_q * s1_bi_q;
  assign p_aibr_d = s1_ai_q * s1_br_q;
  assign sq_x_d   = sq_x * sq_x;
  assign sq_y_d   = sq_y * sq_y;

  logic                 s2_valid_q;
  cau_pkg::cmd_e        s2_cmd_q;
  logic signed [W-1:0]  s2_ar_q, s2_ai_q, s2_br_q, s2_bi_q;
  logic signed [PW-1:0] p_arbr_q, p_aibi_q, p_arbi_q, p_aibr_q, sq_x_q, sq_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cmd_q <= s1_cmd_q;
      s2_ar_q  <= s1_ar_q;
      s2_ai_q  <= s1_ai_q;
      s2_br_q  <= s1_br_q;
      s2_bi_q  <= s1_bi_q;
      p_arbr_q <= p_arbr_d;
      p_aibi_q <= p_aibi_d;
      p_arbi_q <= p_arbi_d;
      p_aibr_q <= p_aibr_d;
      sq_x_q   <= sq_x_d;
      sq_y_q   <= sq_y_d;
    end
  end

  // ---------------- stage 3: sums, rounding, divider operands ----------------
  logic                 isdiv_d;
  logic [DB-1:0]        den_d;
  logic signed [SW-1:0] num_re_d, num_im_d, val_re_d, val_im_d;

  always_comb begin
    isdiv_d  = 1'b0;
    den_d    = '0;
    num_re_d = '0;
    num_im_d = '0;
    val_re_d = '0;
    val_im_d = '0;
    unique case (s2_cmd_q)
      cau_pkg::CMD_ADD: begin
        val_re_d = SW'(s2_ar_q) + SW'(s2_br_q);
        val_im_d = SW'(s2_ai_q) + SW'(s2_bi_q);
      end
      cau_pkg::CMD_SUB: begin
        val_re_d = SW'(s2_ar_q) - SW'(s2_br_q);
        val_im_d = SW'(s2_ai_q) - SW'(s2_bi_q);
      end
      cau_pkg::CMD_MUL: begin
        val_re_d = (SW'(p_arbr_q) - SW'(p_aibi_q) + RND) >>> F;
        val_im_d = (SW'(p_arbi_q) + SW'(p_aibr_q) + RND) >>> F;
      end
      cau_pkg::CMD_SCALE: begin
        val_re_d = (SW'(p_arbr_q) + RND) >>> F;
        val_im_d = (SW'(p_aibr_q) + RND) >>> F;
      end
      cau_pkg::CMD_DIV: begin
        isdiv_d  = 1'b1;
        den_d    = $unsigned(sq_x_q) + $unsigned(sq_y_q);
        num_re_d = SW'(p_arbr_q) + SW'(p_aibi_q);
        num_im_d = SW'(p_aibr_q) - SW'(p_arbi_q);
      end
      cau_pkg::CMD_DIVR: begin
        // move the divisor sign onto the numerators
        isdiv_d  = 1'b1;
        den_d    = DB'(s2_br_q[W-1] ? -SW'(s2_br_q) : SW'(s2_br_q));
        num_re_d = s2_br_q[W-1] ? -SW'(s2_ar_q) : SW'(s2_ar_q);
        num_im_d = s2_br_q[W-1] ? -SW'(s2_ai_q) : SW'(s2_ai_q);
      end
      cau_pkg::CMD_RECIP: begin
        isdiv_d  = 1'b1;
        den_d    = $unsigned(sq_x_q) + $unsigned(sq_y_q);
        num_re_d = SW'(p_arbr_q);
        num_im_d = -SW'(p_aibr_q);
      end
      default: begin
      end
    endcase
  end

  logic                 s3_valid_q, s3_isdiv_q;
  logic [DB-1:0]        s3_den_q;
  logic signed [SW-1:0] s3_num_re_q, s3_num_im_q, s3_val_re_q, s3_val_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_isdiv_q  <= isdiv_d;
      s3_den_q    <= den_d;
      s3_num_re_q <= num_re_d;
      s3_num_im_q <= num_im_d;
      s3_val_re_q <= val_re_d;
      s3_val_im_q <= val_im_d;
    end
  end

  // ---------------- stage 4: numerator magnitudes ----------------
  logic                 s4_valid_q, s4_isdiv_q, s4_neg_re_q, s4_neg_im_q;
  logic [DB-1:0]        s4_den_q, s4_mag_re_q, s4_mag_im_q;
  logic signed [SW-1:0] s4_val_re_q, s4_val_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_isdiv_q  <= s3_isdiv_q;
      s4_den_q    <= s3_den_q;
      s4_neg_re_q <= s3_num_re_q[SW-1];
      s4_neg_im_q <= s3_num_im_q[SW-1];
      s4_mag_re_q <= DB'(s3_num_re_q[SW-1] ? -s3_num_re_q : s3_num_re_q);
      s4_mag_im_q <= DB'(s3_num_im_q[SW-1] ? -s3_num_im_q : s3_num_im_q);
      s4_val_re_q <= s3_val_re_q;
      s4_val_im_q <= s3_val_im_q;
    end
  end

  // ---------------- stage 5: overflow check, divider seed ----------------
  logic [NB-1:0] n_re, n_im;
  dstage_t       seed;

  assign n_re = NB'(s4_mag_re_q) << F;
  assign n_im = NB'(s4_mag_im_q) << F;

  always_comb begin
    seed.isdiv  = s4_isdiv_q;
    seed.dz     = s4_isdiv_q & (s4_den_q == '0);
    // quotient needs more than W bits when n >= den * 2^W
    seed.ovf_re = (n_re >> W) >= NB'(s4_den_q);
    seed.ovf_im = (n_im >> W) >= NB'(s4_den_q);
    seed.neg_re = s4_neg_re_q;
    seed.neg_im = s4_neg_im_q;
    seed.den    = s4_den_q;
    seed.rem_re = DB'(n_re >> W);
    seed.rem_im = DB'(n_im >> W);
    seed.nq_re  = n_re[W-1:0];
    seed.nq_im  = n_im[W-1:0];
    seed.val_re = s4_val_re_q;
    seed.val_im = s4_val_im_q;
  end

  logic    dv_q [W+1];
  dstage_t dp_q [W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp_q[0] <= seed;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [DB:0] t_re, t_im;
    logic        ge_re, ge_im;
    dstage_t     nxt;

    assign t_re  = {dp_q[k].rem_re, dp_q[k].nq_re[W-1]};
    assign t_im  = {dp_q[k].rem_im, dp_q[k].nq_im[W-1]};
    assign ge_re = t_re >= {1'b0, dp_q[k].den};
    assign ge_im = t_im >= {1'b0, dp_q[k].den};

    always_comb begin
      nxt        = dp_q[k];
      nxt.rem_re = ge_re ? DB'(t_re - {1'b0, dp_q[k].den}) : t_re[DB-1:0];
      nxt.rem_im = ge_im ? DB'(t_im - {1'b0, dp_q[k].den}) : t_im[DB-1:0];
      nxt.nq_re  = {dp_q[k].nq_re[W-2:0], ge_re};
      nxt.nq_im  = {dp_q[k].nq_im[W-2:0], ge_im};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dp_q[k+1] <= nxt;
      end
    end
  end

  // ---------------- final stage: round, sign, saturate ----------------
  // returns {saturated, value}
  function automatic logic [W:0] finish(input logic isdiv, input logic ovf,
                                        input logic neg, input logic [W-1:0] q,
                                        input logic [DB-1:0] rem,
                                        input logic [DB-1:0] den,
                                        input logic signed [SW-1:0] val);
    logic [W:0]   qr;
    logic         big;
    logic [W-1:0] v;
    logic         sat;
    qr  = {1'b0, q} + (W+1)'({rem, 1'b0} >= {1'b0, den});
    big = neg ? (qr > HALFW) : (qr > HALFW - (W+1)'(1));
    v   = W'(neg ? -qr : qr);
    sat = ovf | big;
    if (isdiv) begin
      finish = {sat, sat ? (neg ? SMIN : SMAX) : v};
    end else begin
      sat    = ~((&val[SW-1:W-1]) | ~(|val[SW-1:W-1]));
      finish = {sat, sat ? (val[SW-1] ? SMIN : SMAX) : val[W-1:0]};
    end
  endfunction

  dstage_t                  dl;
  logic [W:0]               f_re, f_im;
  logic [W-1:0]             fin_re_d, fin_im_d;
  cau_pkg::status_e         fin_st_d;

  assign dl   = dp_q[W];
  assign f_re = finish(dl.isdiv, dl.ovf_re, dl.neg_re, dl.nq_re, dl.rem_re, dl.den,
                       dl.val_re);
  assign f_im = finish(dl.isdiv, dl.ovf_im, dl.neg_im, dl.nq_im, dl.rem_im, dl.den,
                       dl.val_im);

  always_comb begin
    priority if (dl.dz) begin
      fin_re_d = '0;
      fin_im_d = '0;
      fin_st_d = cau_pkg::ST_DIVZRO;
    end else begin
      fin_re_d = f_re[W-1:0];
      fin_im_d = f_im[W-1:0];
      fin_st_d = (f_re[W] | f_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  logic             fin_valid_q;
  logic [W-1:0]     fin_re_q, fin_im_q;
  cau_pkg::status_e fin_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en) begin
      fin_valid_q <= dv_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_re_q <= fin_re_d;
      fin_im_q <= fin_im_d;
      fin_st_q <= fin_st_d;
    end
  end

  // ---------------- output register and skid ----------------
  logic             out_valid_q;
  logic [W-1:0]     out_re_q, out_im_q, skid_re_q, skid_im_q;
  cau_pkg::status_e out_st_q, skid_st_q;
  logic             push, take;

  assign push = fin_valid_q & en;
  assign take = out_valid_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_re_q <= skid_re_q;
        out_im_q <= skid_im_q;
        out_st_q <= skid_st_q;
      end
    end else if (push) begin
      if (out_valid_q && !take) begin
        skid_re_q <= fin_re_q;
        skid_im_q <= fin_im_q;
        skid_st_q <= fin_st_q;
      end else begin
        out_re_q <= fin_re_q;
        out_im_q <= fin_im_q;
        out_st_q <= fin_st_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'({out_im_q, out_re_q});
  assign m_axis_tuser  = out_st_q;

  // ---------------- assertions ----------------
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid filled while output was free");

  a_skid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == cau_pkg::ST_DIVZRO) |-> (m_axis_tdata == '0))
    else $error("divide by zero result is not zero");

  a_dz_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[W] && dl.dz) |-> dl.isdiv)
    else $error("zero divisor flagged on a non-divide command");

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for complex_arith_unit: directed table plus random transactions,
// checked against a bit-exact predictor. Depends on cau_pkg and the unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int F = 16;
  localparam int LAT = W + 7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] a_re, a_im, b_re, b_im;
  } op_t;

  typedef struct packed {
    logic [31:0] re, im;
    logic [1:0]  st;
    logic        known;
  } res_t;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  complex_arith_unit u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  res_t pending_q[$];
  int errors = 0, n_sent = 0, n_got = 0;
  bit done_sending = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Round a double-width product: add half an LSB, shift arithmetic.
  function automatic logic signed [127:0] round_prod(input logic signed [127:0] p);
    return (p + (128'sd1 <<< (F - 1))) >>> F;
  endfunction

  // num * 2^F / den, den positive, ties away from zero.
  function automatic logic signed [127:0] div_round(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
    logic [127:0] m, q;
    logic neg;
    neg = num[127];
    m = neg ? -num : num;
    m = (m << (F + 1)) + den;
    q = m / (den << 1);
    return neg ? -q : q;
  endfunction

  function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1; return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1; return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic res_t predict_cplx(input op_t op);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic sat, dz;
    res_t r;
    ar = $signed(op.a_re); ai = $signed(op.a_im);
    br = $signed(op.b_re); bi = $signed(op.b_im);
    re = 0; im = 0; sat = 0; dz = 0;
    case (op.cmd)
      cau_pkg::CMD_ADD: begin re = ar + br; im = ai + bi; end
      cau_pkg::CMD_SUB: begin re = ar - br; im = ai - bi; end
      cau_pkg::CMD_MUL: begin
        re = round_prod(ar * br - ai * bi);
        im = round_prod(ar * bi + ai * br);
      end
      cau_pkg::CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) dz = 1;
        else begin
          re = div_round(ar * br + ai * bi, den);
          im = div_round(ai * br - ar * bi, den);
        end
      end
      cau_pkg::CMD_SCALE: begin re = round_prod(ar * br); im = round_prod(ai * br); end
      cau_pkg::CMD_DIVR: begin
        if (br == 0) dz = 1;
        else if (br < 0) begin
          re = div_round(-ar, -br); im = div_round(-ai, -br);
        end else begin
          re = div_round(ar, br); im = div_round(ai, br);
        end
      end
      cau_pkg::CMD_RECIP: begin
        den = ar * ar + ai * ai;
        if (den == 0) dz = 1;
        else begin
          re = div_round(br * ar, den);
          im = div_round(-(br * ai), den);
        end
      end
      default: ;
    endcase
    r.known = 1;
    if (dz) begin
      r.re = 0; r.im = 0; r.st = cau_pkg::ST_DIVZRO;
    end else begin
      r.re = clamp(re, sat);
      r.im = clamp(im, sat);
      r.st = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
    return r;
  endfunction

  // Directed rows: operation plus the typed-in result where obvious.
  localparam logic [31:0] MX = 32'h7fffffff, MN = 32'h80000000, ONE = 32'h00010000;
  typedef struct packed { op_t op; res_t want; } row_t;
  row_t dir_tab[] = '{
    '{'{cau_pkg::CMD_ADD, 0, 0, 0, 0}, '{0, 0, cau_pkg::ST_OK, 1}},
    '{'{cau_pkg::CMD_ADD, MX, MN, ONE, MN}, '{MX, MN, cau_pkg::ST_SAT, 1}},
    '{'{cau_pkg::CMD_SUB, MN, MX, ONE, MN}, '{MN, MX, cau_pkg::ST_SAT, 1}},
    '{'{cau_pkg::CMD_SUB, MX, MN, MX, MN}, '{0, 0, cau_pkg::ST_OK, 1}},
    '{'{cau_pkg::CMD_MUL, ONE, ONE, ONE, ONE}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_MUL, MX, MX, MX, MN}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_MUL, MN, MN, MN, MN}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_MUL, 32'h00008000, 0, 1, 0}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_MUL, 32'hffff8000, 0, 1, 0}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_DIV, ONE, MX, 0, 0}, '{0, 0, cau_pkg::ST_DIVZRO, 1}},
    '{'{cau_pkg::CMD_DIV, ONE, 0, ONE, 0}, '{ONE, 0, cau_pkg::ST_OK, 1}},
    '{'{cau_pkg::CMD_DIV, MX, MN, 1, 1}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_DIV, MN, MN, MN, MN}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_DIV, 3, 5, 32'hfffffffe, 7}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_SCALE, MX, MN, MN, 5}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_SCALE, ONE, 32'hffff0000, ONE, 9},
      '{ONE, 32'hffff0000, cau_pkg::ST_OK, 1}},
    '{'{cau_pkg::CMD_DIVR, MX, MX, 0, ONE}, '{0, 0, cau_pkg::ST_DIVZRO, 1}},
    '{'{cau_pkg::CMD_DIVR, MX, MN, 1, 0}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_DIVR, MN, MX, MN, 3}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_DIVR, 1, 32'hffffffff, 2, 0}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_RECIP, 0, 0, ONE, 4}, '{0, 0, cau_pkg::ST_DIVZRO, 1}},
    '{'{cau_pkg::CMD_RECIP, ONE, 0, ONE, 0}, '{ONE, 0, cau_pkg::ST_OK, 1}},
    '{'{cau_pkg::CMD_RECIP, 1, 0, MX, 0}, '{0, 0, 0, 0}},
    '{'{cau_pkg::CMD_RECIP, MN, MX, MN, 0}, '{0, 0, 0, 0}},
    '{'{3'd7, MX, MN, MX, MN}, '{0, 0, cau_pkg::ST_OK, 1}}
  };

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return MX;
      1: return MN;
      2: return $urandom_range(0, 1) ? 0 : ONE;
      3: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? '1 : '0);
      default: return $urandom;
    endcase
  endfunction

  // Send one transaction after a random gap, queue its expected result.
  // Called and returning at a falling edge.
  task automatic send_op(input op_t op, input res_t want);
    res_t p;
    int gap;
    gap = $urandom_range(0, 7);
    p = predict_cplx(op);
    if (want.known && want != p) report($sformatf("directed row %0d disagrees", n_sent));
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    pending_q.push_back(p);
    s_axis_tdata <= {op.b_im, op.b_re, op.a_im, op.a_re};
    s_axis_tuser <= op.cmd;
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    op_t op;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    foreach (dir_tab[i]) send_op(dir_tab[i].op, dir_tab[i].want);
    for (int i = 0; i < 850; i++) begin
      op.cmd = $urandom_range(0, 15) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
      op.a_re = rand_word(); op.a_im = rand_word();
      op.b_re = rand_word(); op.b_im = rand_word();
      if ($urandom_range(0, 20) == 0) begin
        op.b_re = 0; op.b_im = 0;
      end
      send_op(op, '0);
    end
    s_axis_tvalid <= 0;
    done_sending = 1;
  end

  // Output side: random stall before each result, long run of no stalls midway.
  initial begin
    int gap;
    @(negedge clk_i);
    forever begin
      gap = (n_got > 300 && n_got < 400) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_got++;
      if (pending_q.size() == 0) report("result with no expectation");
      else begin
        w = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== w.re)
          report($sformatf("re got %h want %h", m_axis_tdata[31:0], w.re));
        if (m_axis_tdata[63:32] !== w.im)
          report($sformatf("im got %h want %h", m_axis_tdata[63:32], w.im));
        if (m_axis_tuser !== w.st)
          report($sformatf("status got %0d want %0d", m_axis_tuser, w.st));
      end
    end
  end

  initial begin
    wait (done_sending && pending_q.size() == 0);
    repeat (LAT + 20) @(posedge clk_i);
    $display("Checked %0d of %0d transactions over all seven commands and the unused code,",
             n_got, n_sent);
    $display("including saturation, zero divisors and rounding ties.");
    if (errors == 0 && pending_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
